FILE: sv/fhkv_pkg.sv
// ----------------------------------------------------------------------------
// fhkv_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fhkv_pkg;

	localparam int CAPACITY_DEF      = 1024;
	localparam int PROBE_SPAN_DEF    = 8;
	localparam int MAX_KEY_BYTES_DEF = 8;

	localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
	localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
	localparam int          FNV_PRIME_SH = 40;

	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_PUT = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EXISTS    = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic       clr_step;
		logic       load;
		logic       hash_step;
		logic [2:0] byte_sel;
		logic       mod_step;
		logic [3:0] nib_sel;
		logic       probe_init;
		logic       rd;
		logic       advance;
		logic       wr_ins;
		logic       wr_del;
		logic       set_res;
		logic [1:0] res_status;
		logic       res_keep_val;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       slot_valid;
		logic       match;
		logic [1:0] op;
		logic [3:0] len;
	} sts_t;

endpackage

FILE: sv/fhkv_datapath.sv
// ----------------------------------------------------------------------------
// fhkv_datapath
// Hash, remainder, probe index and slot memory under controller commands.
// ----------------------------------------------------------------------------
module fhkv_datapath #(
	parameter int CAPACITY      = fhkv_pkg::CAPACITY_DEF,
	parameter int MAX_KEY_BYTES = fhkv_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fhkv_pkg::cmd_t    cmd,
	output fhkv_pkg::sts_t    sts,
	input  logic [1:0]        opcode,
	input  logic [63:0]       key_bytes,
	input  logic [3:0]        key_len,
	input  logic [63:0]       put_value,
	output logic              done,
	output logic [1:0]        status,
	output logic [63:0]       result_value
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RW = IW + 5;
	localparam int DW = 1 + 4 + 64 + 64;
	localparam logic [IW-1:0] IDX_LAST = IW'(CAPACITY - 1);
	localparam logic [RW-1:0] CAP_R    = RW'(CAPACITY);

	logic [DW-1:0] mem [CAPACITY];

	logic [1:0]    op_q;
	logic [3:0]    len_q;
	logic [63:0]   key_q;
	logic [63:0]   val_q;
	logic [63:0]   h_q;
	logic [63:0]   hcur_q;
	logic [IW-1:0] rem_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] clr_q;
	logic [DW-1:0] rd_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [63:0]   result_q;

	logic [3:0]    len_sat;
	logic [63:0]   key_msk;
	logic [72:0]   h_lo;
	logic [63:0]   h_next;
	logic [RW-1:0] red;
	logic [IW-1:0] idx_inc;

	always_comb begin
		len_sat = (key_len > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_len;
		for (int b = 0; b < 8; b++) begin
			key_msk[b*8 +: 8] = (4'(b) < len_sat) ? key_bytes[b*8 +: 8] : 8'h00;
		end
	end

	always_comb begin
		h_lo   = h_q * fhkv_pkg::FNV_PRIME_LO;
		h_next = ({h_q[63-fhkv_pkg::FNV_PRIME_SH:0], {fhkv_pkg::FNV_PRIME_SH{1'b0}}}
			+ h_lo[63:0]) ^ {56'h0, key_q[cmd.byte_sel*8 +: 8]};
	end

	always_comb begin
		red = {1'b0, rem_q, h_q[cmd.nib_sel*4 +: 4]};
		for (int k = 3; k >= 0; k--) begin
			if (red >= (CAP_R << k)) begin
				red = red - (CAP_R << k);
			end
		end
	end

	always_comb begin
		if (hcur_q == {64{1'b1}} || idx_q == IDX_LAST) begin
			idx_inc = '0;
		end else begin
			idx_inc = idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			done_q <= cmd.set_res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			len_q <= len_sat;
			key_q <= key_msk;
			val_q <= put_value;
			h_q   <= fhkv_pkg::FNV_BASIS;
			rem_q <= '0;
		end
		if (cmd.hash_step) begin
			h_q <= h_next;
		end
		if (cmd.mod_step) begin
			rem_q <= red[IW-1:0];
		end
		if (cmd.probe_init) begin
			idx_q  <= rem_q;
			hcur_q <= h_q;
		end
		if (cmd.advance) begin
			idx_q  <= idx_inc;
			hcur_q <= hcur_q + 64'd1;
		end
		if (cmd.set_res) begin
			status_q <= cmd.res_status;
			result_q <= cmd.res_keep_val ? rd_q[63:0] : 64'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_q] <= '0;
		end else if (cmd.wr_ins) begin
			mem[idx_q] <= {1'b1, len_q, key_q, val_q};
		end else if (cmd.wr_del) begin
			mem[idx_q] <= {1'b0, rd_q[DW-2:0]};
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q];
		end
	end

	assign sts.clr_last   = (clr_q == IDX_LAST);
	assign sts.slot_valid = rd_q[DW-1];
	assign sts.match      = rd_q[DW-1] && (rd_q[DW-2 -: 4] == len_q)
		&& (rd_q[127:64] == key_q);
	assign sts.op         = op_q;
	assign sts.len        = len_q;

	assign done         = done_q;
	assign status       = status_q;
	assign result_value = result_q;

endmodule

FILE: sv/fhkv_ctrl.sv
// ----------------------------------------------------------------------------
// fhkv_ctrl
// Sequencer: memory clear, hash steps, remainder steps and slot probes.
// ----------------------------------------------------------------------------
module fhkv_ctrl #(
	parameter int PROBE_SPAN = fhkv_pkg::PROBE_SPAN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  fhkv_pkg::sts_t sts,
	output fhkv_pkg::cmd_t cmd
);

	localparam int PW = $clog2(PROBE_SPAN + 1);
	localparam logic [PW-1:0] P_LAST = PW'(PROBE_SPAN - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_PINIT = 3'd4;
	localparam logic [2:0] S_RD    = 3'd5;
	localparam logic [2:0] S_CMP   = 3'd6;

	logic [2:0]    state_q, state_d;
	logic [3:0]    cnt_q, cnt_d;
	logic [PW-1:0] pcnt_q, pcnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		pcnt_d  = pcnt_q;
		cmd     = '0;
		cmd.byte_sel = cnt_q[2:0];
		cmd.nib_sel  = 4'd15 - cnt_q;
		busy    = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				if (cnt_q == sts.len) begin
					cnt_d   = '0;
					state_d = S_MOD;
				end else begin
					cmd.hash_step = 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 4'd15) begin
					state_d = S_PINIT;
				end
			end
			S_PINIT: begin
				cmd.probe_init = 1'b1;
				pcnt_d  = '0;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_IDLE;
				cmd.set_res = 1'b1;
				if (sts.op == fhkv_pkg::OP_PUT) begin
					if (!sts.slot_valid) begin
						cmd.wr_ins     = 1'b1;
						cmd.res_status = fhkv_pkg::ST_OK;
					end else if (sts.match) begin
						cmd.res_status   = fhkv_pkg::ST_EXISTS;
						cmd.res_keep_val = 1'b1;
					end else if (pcnt_q == P_LAST) begin
						cmd.res_status = fhkv_pkg::ST_FULL;
					end else begin
						cmd.set_res = 1'b0;
						cmd.advance = 1'b1;
						pcnt_d  = pcnt_q + 1'b1;
						state_d = S_RD;
					end
				end else if (sts.op inside {fhkv_pkg::OP_GET, fhkv_pkg::OP_DEL}) begin
					if (sts.match) begin
						cmd.wr_del       = (sts.op == fhkv_pkg::OP_DEL);
						cmd.res_status   = fhkv_pkg::ST_OK;
						cmd.res_keep_val = 1'b1;
					end else if (pcnt_q == P_LAST) begin
						cmd.res_status = fhkv_pkg::ST_NOT_FOUND;
					end else begin
						cmd.set_res = 1'b0;
						cmd.advance = 1'b1;
						pcnt_d  = pcnt_q + 1'b1;
						state_d = S_RD;
					end
				end else begin
					cmd.res_status = fhkv_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			pcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pcnt_q  <= pcnt_d;
		end
	end

endmodule

FILE: sv/fnv_hashed_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// fnv_hashed_key_value_table_unit
// Open-addressing key-value table, FNV-1 64-bit hash, linear probe window.
// ----------------------------------------------------------------------------
// channel   handshake           beat fields
// request   start & !busy       opcode, key_bytes, key_len, put_value
// response  done (one cycle)    status, result_value
//
// After reset the slot memory is cleared, one slot a cycle, with busy high.
// A request takes a hash step per key byte (up to MAX_KEY_BYTES), a remainder
// step for each of the 16 nibbles of the hash, a probe setup step, and a read
// step and a compare step per probed slot (one memory read port); done is
// registered from the final compare step.
// The response cannot be stalled; busy drops as done rises.
// ----------------------------------------------------------------------------
module fnv_hashed_key_value_table_unit #(
	parameter int CAPACITY      = fhkv_pkg::CAPACITY_DEF,
	parameter int PROBE_SPAN    = fhkv_pkg::PROBE_SPAN_DEF,
	parameter int MAX_KEY_BYTES = fhkv_pkg::MAX_KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_len,
	input  logic [63:0] put_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] result_value
);

	fhkv_pkg::cmd_t cmd;
	fhkv_pkg::sts_t sts;

	fhkv_ctrl #(
		.PROBE_SPAN(PROBE_SPAN)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	fhkv_datapath #(
		.CAPACITY     (CAPACITY),
		.MAX_KEY_BYTES(MAX_KEY_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.key_bytes   (key_bytes),
		.key_len     (key_len),
		.put_value   (put_value),
		.done        (done),
		.status      (status),
		.result_value(result_value)
	);

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a request in flight");
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == fhkv_pkg::ST_FULL || status == fhkv_pkg::ST_NOT_FOUND)
		|-> result_value == 64'd0)
		else $error("nonzero value on miss or full");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for two cycles");
`endif

endmodule

FILE: tb/sv/tb_fnv_hashed_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// tb_fnv_hashed_key_value_table_unit
// Self-checking regression for the FNV-1 hashed key-value table. Requests
// are sent at random spacing, a behavioral table predicts every response,
// and a scoreboard compares each done beat in order.
// ----------------------------------------------------------------------------
module tb_fnv_hashed_key_value_table_unit;

	localparam int CAP    = fhkv_pkg::CAPACITY_DEF;
	localparam int WIN    = fhkv_pkg::PROBE_SPAN_DEF;
	localparam int MAXKB  = fhkv_pkg::MAX_KEY_BYTES_DEF;
	localparam int LIMIT  = 20000;
	localparam logic [63:0] PRIME = 64'h100000001b3;
	localparam logic [1:0]  OP_BAD = 2'd3;

	typedef struct {
		logic [1:0]  st;
		logic [63:0] val;
	} resp_t;

	class resp_board;
		resp_t pending[$];
		int    errors;

		function void note(resp_t r);
			pending.push_back(r);
		endfunction

		function void check(logic [1:0] st, logic [63:0] val);
			resp_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: status %0d value %h", st, val);
				return;
			end
			e = pending.pop_front();
			if (e.st !== st || e.val !== val) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp status %0d value %h, got status %0d value %h",
						e.st, e.val, st, val);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  opcode = fhkv_pkg::OP_GET;
	logic [63:0] key_bytes = '0;
	logic [3:0]  key_len = '0;
	logic [63:0] put_value = '0;
	logic        busy, done;
	logic [1:0]  status;
	logic [63:0] result_value;

	bit          tbl_valid [CAP];
	logic [63:0] tbl_key   [CAP];
	logic [3:0]  tbl_len   [CAP];
	logic [63:0] tbl_val   [CAP];

	logic [63:0] used_keys [$];
	logic [3:0]  used_lens [$];

	resp_board board = new();
	int          idle_cycles;

	fnv_hashed_key_value_table_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .key_bytes(key_bytes), .key_len(key_len),
		.put_value(put_value), .done(done), .status(status),
		.result_value(result_value)
	);

	always #10 clk = ~clk;

	function automatic resp_t table_access(logic [1:0] op, logic [63:0] kb,
			logic [3:0] kl, logic [63:0] pv);
		resp_t       r;
		logic [3:0]  len;
		logic [63:0] key, h;
		int          s;
		len = (kl > MAXKB) ? 4'(MAXKB) : kl;
		key = (len >= 8) ? kb : (kb & ((64'd1 << (len * 8)) - 64'd1));
		h = fhkv_pkg::FNV_BASIS;
		for (int n = 0; n < len; n++)
			h = (h * PRIME) ^ 64'((key >> (n * 8)) & 64'hff);
		r.st = fhkv_pkg::ST_NOT_FOUND;
		r.val = '0;
		if (op == fhkv_pkg::OP_GET || op == fhkv_pkg::OP_DEL) begin
			for (int i = 0; i < WIN; i++) begin
				s = int'((h + 64'(i)) % 64'(CAP));
				if (tbl_valid[s] && tbl_len[s] == len && tbl_key[s] == key) begin
					r.st = fhkv_pkg::ST_OK;
					r.val = tbl_val[s];
					if (op == fhkv_pkg::OP_DEL)
						tbl_valid[s] = 1'b0;
					break;
				end
			end
		end else if (op == fhkv_pkg::OP_PUT) begin
			r.st = fhkv_pkg::ST_FULL;
			for (int i = 0; i < WIN; i++) begin
				s = int'((h + 64'(i)) % 64'(CAP));
				if (tbl_valid[s]) begin
					if (tbl_len[s] == len && tbl_key[s] == key) begin
						r.st = fhkv_pkg::ST_EXISTS;
						r.val = tbl_val[s];
						break;
					end
				end else begin
					tbl_valid[s] = 1'b1;
					tbl_key[s] = key;
					tbl_len[s] = len;
					tbl_val[s] = pv;
					r.st = fhkv_pkg::ST_OK;
					break;
				end
			end
		end
		return r;
	endfunction

	task automatic pause_random();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
		repeat (n) @(posedge clk);
	endtask

	task automatic send(logic [1:0] op, logic [63:0] kb, logic [3:0] kl, logic [63:0] pv);
		start <= 1'b1;
		opcode <= op;
		key_bytes <= kb;
		key_len <= kl;
		put_value <= pv;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note(table_access(op, kb, kl, pv));
		if (op == fhkv_pkg::OP_PUT) begin
			used_keys.push_back(kb);
			used_lens.push_back(kl);
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_paced(logic [1:0] op, logic [63:0] kb, logic [3:0] kl,
			logic [63:0] pv);
		send(op, kb, kl, pv);
		pause_random();
	endtask

	always @(posedge clk) begin
		if (arst_n && done)
			board.check(status, result_value);
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("fnv_hashed_key_value_table_unit regression: fail");
			$finish;
		end
	end

	initial begin
		logic [63:0] kb;
		logic [3:0]  kl;
		logic [1:0]  op;
		int          k;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_paced(fhkv_pkg::OP_GET, 64'h0, 4'd0, 64'h0);
		send_paced(fhkv_pkg::OP_PUT, 64'h0, 4'd0, 64'hffff_ffff_ffff_ffff);
		send_paced(fhkv_pkg::OP_PUT, 64'hdead, 4'd0, 64'h1);
		send_paced(fhkv_pkg::OP_GET, 64'hffff, 4'd0, 64'h0);
		send_paced(fhkv_pkg::OP_PUT, 64'hffff_ffff_ffff_ffff, 4'd8,
			64'h0123_4567_89ab_cdef);
		send_paced(fhkv_pkg::OP_GET, 64'hffff_ffff_ffff_ffff, 4'd15, 64'h0);
		send_paced(fhkv_pkg::OP_PUT, 64'h0, 4'd1, 64'h55);
		send_paced(fhkv_pkg::OP_PUT, 64'h0, 4'd2, 64'haa);
		send_paced(fhkv_pkg::OP_GET, 64'hff00, 4'd1, 64'h0);
		send_paced(fhkv_pkg::OP_GET, 64'h0, 4'd3, 64'h0);
		send_paced(OP_BAD, 64'h0, 4'd1, 64'h0);
		send_paced(fhkv_pkg::OP_GET, 64'h0, 4'd1, 64'h0);
		send_paced(fhkv_pkg::OP_DEL, 64'h0, 4'd1, 64'h0);
		send_paced(fhkv_pkg::OP_DEL, 64'h0, 4'd1, 64'h0);
		send_paced(fhkv_pkg::OP_GET, 64'h0, 4'd1, 64'h0);
		send_paced(fhkv_pkg::OP_DEL, 64'h0, 4'd0, 64'h0);
		for (int i = 0; i < 10; i++)
			send(fhkv_pkg::OP_PUT, 64'h0, 4'd0, 64'(i));
		send_paced(fhkv_pkg::OP_DEL, 64'h0, 4'd0, 64'h0);

		for (int i = 0; i < 450; i++) begin
			k = $urandom_range(0, 99);
			op = 2'($urandom_range(0, 2));
			kl = 4'($urandom_range(0, 8));
			kb = {$urandom, $urandom};
			if (k < 3)
				op = OP_BAD;
			if (k < 8)
				kl = 4'($urandom_range(9, 15));
			else if (k < 60 && used_keys.size() > 0 && op != fhkv_pkg::OP_PUT) begin
				k = $urandom_range(0, used_keys.size() - 1);
				kb = used_keys[k];
				if ($urandom_range(0, 1) != 0)
					kb = kb | ({$urandom, $urandom} << 32);
				kl = used_lens[k];
			end else if (k < 75) begin
				kl = 4'($urandom_range(0, 1));
				kb = {$urandom, $urandom};
				kb[7:0] = 8'($urandom_range(0, 3));
			end
			send(op, kb, kl, {$urandom, $urandom});
			if ($urandom_range(0, 3) == 0)
				pause_random();
		end

		while (board.pending.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.errors == 0)
			$display("fnv_hashed_key_value_table_unit regression: pass");
		else
			$display("fnv_hashed_key_value_table_unit regression: fail");
		$finish;
	end
endmodule

FILE: filelist.f
sv/fhkv_pkg.sv
sv/fhkv_datapath.sv
sv/fhkv_ctrl.sv
sv/fnv_hashed_key_value_table_unit.sv
tb/sv/tb_fnv_hashed_key_value_table_unit.sv
